// ===== hw/rtl/ptd_pkg.sv =====
`timescale 1ns / 1ps

package ptd_pkg;

  localparam int NUM_PERIODS = 7;
  localparam int PERIOD_W    = 16;
  localparam int TICK_W      = 32;
  localparam int TASK_W      = 3;
  localparam int MODE_W      = 3;
  localparam int ID_W        = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int STEP_W      = 4;
  localparam int ACT_W       = 4;
  localparam int JMP_W       = 2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET [NUM_PERIODS] =
    '{16'd10, 16'd20, 16'd50, 16'd10, 16'd100, 16'd200, 16'd50};

  // input modes
  localparam logic [MODE_W-1:0] M_TICK  = 3'd0;
  localparam logic [MODE_W-1:0] M_START = 3'd1;
  localparam logic [MODE_W-1:0] M_SHUT  = 3'd2;
  localparam logic [MODE_W-1:0] M_ACT   = 3'd3;
  localparam logic [MODE_W-1:0] M_QUERY = 3'd4;

  // microprogram addresses
  localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] S_TICK  = 4'd1;
  localparam logic [STEP_W-1:0] S_PROD  = 4'd2;
  localparam logic [STEP_W-1:0] S_CMP   = 4'd3;
  localparam logic [STEP_W-1:0] S_FLUSH = 4'd4;
  localparam logic [STEP_W-1:0] S_START = 4'd5;
  localparam logic [STEP_W-1:0] S_SHUT  = 4'd6;
  localparam logic [STEP_W-1:0] S_ACT   = 4'd7;
  localparam logic [STEP_W-1:0] S_QUERY = 4'd8;

  // datapath actions
  localparam logic [ACT_W-1:0] A_NONE  = 4'd0;
  localparam logic [ACT_W-1:0] A_TICK  = 4'd1;
  localparam logic [ACT_W-1:0] A_PROD  = 4'd2;
  localparam logic [ACT_W-1:0] A_CMP   = 4'd3;
  localparam logic [ACT_W-1:0] A_FLUSH = 4'd4;
  localparam logic [ACT_W-1:0] A_START = 4'd5;
  localparam logic [ACT_W-1:0] A_SHUT  = 4'd6;
  localparam logic [ACT_W-1:0] A_ACT   = 4'd7;
  localparam logic [ACT_W-1:0] A_QUERY = 4'd8;

  // sequencer jumps
  localparam logic [JMP_W-1:0] J_NEXT     = 2'd0;
  localparam logic [JMP_W-1:0] J_GOTO     = 2'd1;
  localparam logic [JMP_W-1:0] J_DISPATCH = 2'd2;
  localparam logic [JMP_W-1:0] J_LOOP     = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   task_id;
  } item_t;

  typedef struct packed {
    logic              due;
    logic [TASK_W-1:0] due_task;
    logic [TICK_W-1:0] tick_now;
    logic              task_state;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [JMP_W-1:0]  jmp;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic running;
    logic scan_more;
  } status_t;

  function automatic ctrl_t prog_rom(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{act: A_NONE, jmp: J_GOTO, target: S_IDLE};
    unique case (step)
      S_IDLE:  w = '{act: A_NONE,  jmp: J_DISPATCH, target: S_IDLE};
      S_TICK:  w = '{act: A_TICK,  jmp: J_NEXT,     target: S_IDLE};
      S_PROD:  w = '{act: A_PROD,  jmp: J_NEXT,     target: S_IDLE};
      S_CMP:   w = '{act: A_CMP,   jmp: J_LOOP,     target: S_PROD};
      S_FLUSH: w = '{act: A_FLUSH, jmp: J_GOTO,     target: S_IDLE};
      S_START: w = '{act: A_START, jmp: J_GOTO,     target: S_FLUSH};
      S_SHUT:  w = '{act: A_SHUT,  jmp: J_GOTO,     target: S_FLUSH};
      S_ACT:   w = '{act: A_ACT,   jmp: J_GOTO,     target: S_FLUSH};
      S_QUERY: w = '{act: A_QUERY, jmp: J_GOTO,     target: S_IDLE};
      default: w = '{act: A_NONE,  jmp: J_GOTO,     target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/ptd_seq.sv =====
`timescale 1ns / 1ps

module ptd_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [ptd_pkg::MODE_W-1:0] mode,
  input  ptd_pkg::status_t          status,
  output ptd_pkg::ctrl_t            ctrl,
  output logic                      busy
);

  logic [ptd_pkg::STEP_W-1:0] step;
  logic [ptd_pkg::STEP_W-1:0] step_next;
  logic [ptd_pkg::STEP_W-1:0] dispatch;

  assign ctrl = ptd_pkg::prog_rom(step);
  assign busy = (step != ptd_pkg::S_IDLE);

  always_comb begin
    unique case (mode)
      ptd_pkg::M_TICK:  dispatch = status.running ? ptd_pkg::S_TICK : ptd_pkg::S_FLUSH;
      ptd_pkg::M_START: dispatch = ptd_pkg::S_START;
      ptd_pkg::M_SHUT:  dispatch = ptd_pkg::S_SHUT;
      ptd_pkg::M_ACT:   dispatch = ptd_pkg::S_ACT;
      ptd_pkg::M_QUERY: dispatch = ptd_pkg::S_QUERY;
      default:          dispatch = ptd_pkg::S_FLUSH;
    endcase
  end

  always_comb begin
    unique case (ctrl.jmp)
      ptd_pkg::J_NEXT:     step_next = step + 1'b1;
      ptd_pkg::J_GOTO:     step_next = ctrl.target;
      ptd_pkg::J_DISPATCH: step_next = accept ? dispatch : step;
      ptd_pkg::J_LOOP:     step_next = status.scan_more ? ctrl.target : step + 1'b1;
      default:             step_next = ptd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ptd_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== hw/rtl/ptd_datapath.sv =====
`timescale 1ns / 1ps

module ptd_datapath #(
  parameter int TICK_MS      = 1,
  parameter int MAX_SLOTS    = 8,
  parameter int ACTIVE_TASKS = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  ptd_pkg::item_t                cmd,
  input  ptd_pkg::ctrl_t                ctrl,
  input  logic                          cfg_valid,
  input  logic [ptd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptd_pkg::PERIOD_W-1:0]  cfg_data,
  output ptd_pkg::status_t              status,
  output ptd_pkg::result_t              result,
  output logic                          result_valid
);

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int MUL_W = $clog2(TICK_MS + 1);
  localparam int PRD_W = ptd_pkg::TICK_W + MUL_W;

  logic [ptd_pkg::PERIOD_W-1:0] period [ptd_pkg::NUM_PERIODS];
  logic [ptd_pkg::TICK_W-1:0]   last_run [MAX_SLOTS];
  logic [MAX_SLOTS-1:0]         rdy;
  logic [ptd_pkg::TICK_W-1:0]   tick;
  logic                         running;
  logic [IDX_W-1:0]             idx;
  logic [ptd_pkg::TICK_W-1:0]   prod;
  logic                         pend;
  logic [IDX_W-1:0]             pend_task;
  ptd_pkg::item_t               item;

  logic [PRD_W-1:0]             prod_full;
  logic                         id_ok;
  logic [IDX_W-1:0]             id_slot;
  logic                         hit;

  assign prod_full = PRD_W'(tick - last_run[idx]) * PRD_W'(TICK_MS);
  assign id_ok     = (item.task_id < ptd_pkg::ID_W'(MAX_SLOTS));
  assign id_slot   = item.task_id[IDX_W-1:0];
  assign hit       = rdy[idx] && (prod >= ptd_pkg::TICK_W'(period[idx]));

  assign status.running   = running;
  assign status.scan_more = (idx != IDX_W'(ACTIVE_TASKS - 1));

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= cmd;
    end
    if (ctrl.act == ptd_pkg::A_PROD) begin
      prod <= prod_full[ptd_pkg::TICK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ptd_pkg::NUM_PERIODS; i++) begin
        period[i] <= ptd_pkg::PERIOD_RESET[i];
      end
      for (int i = 0; i < MAX_SLOTS; i++) begin
        last_run[i] <= '0;
      end
      rdy          <= '0;
      tick         <= '0;
      running      <= 1'b0;
      idx          <= '0;
      pend         <= 1'b0;
      pend_task    <= '0;
      result       <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && (cfg_index < ptd_pkg::CFG_IDX_W'(ptd_pkg::NUM_PERIODS))) begin
        period[cfg_index] <= cfg_data;
      end
      unique case (ctrl.act)
        ptd_pkg::A_TICK: begin
          tick <= tick + 1'b1;
          idx  <= '0;
          pend <= 1'b0;
        end
        ptd_pkg::A_CMP: begin
          // emit the previous due slot once another one turns up
          if (hit) begin
            last_run[idx] <= tick;
            pend          <= 1'b1;
            pend_task     <= idx;
            if (pend) begin
              result       <= '{due: 1'b1, due_task: ptd_pkg::TASK_W'(pend_task),
                                tick_now: tick, task_state: 1'b0, last: 1'b0};
              result_valid <= 1'b1;
            end
          end
          idx <= idx + 1'b1;
        end
        ptd_pkg::A_FLUSH: begin
          result       <= '{due: pend,
                            due_task: pend ? ptd_pkg::TASK_W'(pend_task) : '0,
                            tick_now: tick, task_state: 1'b0, last: 1'b1};
          result_valid <= 1'b1;
          pend         <= 1'b0;
        end
        ptd_pkg::A_START: begin
          for (int i = 0; i < ACTIVE_TASKS; i++) begin
            rdy[i]      <= 1'b1;
            last_run[i] <= '0;
          end
          running <= 1'b1;
        end
        ptd_pkg::A_SHUT: begin
          running <= 1'b0;
        end
        ptd_pkg::A_ACT: begin
          if (id_ok) begin
            rdy[id_slot] <= 1'b1;
          end
        end
        ptd_pkg::A_QUERY: begin
          result       <= '{due: 1'b0, due_task: '0, tick_now: tick,
                            task_state: id_ok && rdy[id_slot], last: 1'b1};
          result_valid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/periodic_task_dispatcher.sv =====
`timescale 1ns / 1ps

// Start/shutdown/activate, query, unused modes and a stopped tick each give one result; a running
// tick gives one per due slot (or one if none is due), its final result from the flush step.
// Busy stays high while the microprogram steps one slot at a time through a shared multiplier and
// comparator in two steps; no new item is taken until busy falls.
// Results appear for one cycle on result_valid; the receiver cannot stall them.
// Reset (rst, synchronous): stopped, all slots suspended, counters zero, periods default.
module periodic_task_dispatcher #(
  parameter int TICK_MS      = 1,
  parameter int MAX_SLOTS    = 8,
  parameter int ACTIVE_TASKS = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  ptd_pkg::item_t                cmd,
  output ptd_pkg::result_t              result,
  output logic                          result_valid,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ptd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptd_pkg::PERIOD_W-1:0]  cfg_data
);

  ptd_pkg::ctrl_t   ctrl;
  ptd_pkg::status_t status;
  logic             accept;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  ptd_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .mode   (cmd.mode),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  ptd_datapath #(
    .TICK_MS      (TICK_MS),
    .MAX_SLOTS    (MAX_SLOTS),
    .ACTIVE_TASKS (ACTIVE_TASKS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .cmd          (cmd),
    .ctrl         (ctrl),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .status       (status),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

// ===== sim/ptd_checker.sv =====
`timescale 1ns / 1ps

module ptd_checker
  import ptd_pkg::*;
#(
  parameter int TICK_MS      = 1,
  parameter int MAX_SLOTS    = 8,
  parameter int ACTIVE_TASKS = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  item_t                cmd,
  input  result_t              result,
  input  logic                 result_valid,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PERIOD_W-1:0]  cfg_data,
  output int                   mismatches,
  output int                   outstanding,
  output int                   commands,
  output int                   dispatches
);

  logic [PERIOD_W-1:0] period [NUM_PERIODS];
  logic [TICK_W-1:0]   tick_count;
  logic [TICK_W-1:0]   last_run [MAX_SLOTS];
  logic                ready [MAX_SLOTS];
  logic                running;
  result_t             scheduled_results [$];

  function automatic result_t make_result(input logic d, input logic [TASK_W-1:0] slot,
                                          input logic st, input logic fin);
    result_t r;
    r.due        = d;
    r.due_task   = slot;
    r.tick_now   = tick_count;
    r.task_state = st;
    r.last       = fin;
    return r;
  endfunction

  // Update the slot table for one item and queue the results it causes.
  task automatic advance_schedule(input item_t it);
    logic [TICK_W-1:0] since;
    logic              st;
    result_t           r;
    int                n;
    n = 0;
    case (it.mode)
      M_TICK: begin
        if (running) begin
          tick_count = tick_count + 1'b1;
          for (int i = 0; i < ACTIVE_TASKS && i < NUM_PERIODS && i < MAX_SLOTS; i++) begin
            if (ready[i]) begin
              since = tick_count * TICK_W'(TICK_MS) - last_run[i] * TICK_W'(TICK_MS);
              if (since >= TICK_W'(period[i])) begin
                last_run[i] = tick_count;
                scheduled_results.push_back(make_result(1'b1, TASK_W'(i), 1'b0, 1'b0));
                n++;
                dispatches++;
              end
            end
          end
        end
      end
      M_START: begin
        for (int i = 0; i < ACTIVE_TASKS && i < MAX_SLOTS; i++) begin
          ready[i]    = 1'b1;
          last_run[i] = '0;
        end
        running = 1'b1;
      end
      M_SHUT: begin
        running = 1'b0;
      end
      M_ACT: begin
        if (it.task_id < MAX_SLOTS) ready[it.task_id] = 1'b1;
      end
      M_QUERY: begin
        st = (it.task_id < MAX_SLOTS) ? ready[it.task_id] : 1'b0;
        scheduled_results.push_back(make_result(1'b0, '0, st, 1'b1));
        return;
      end
      default: ;
    endcase
    if (n == 0) begin
      scheduled_results.push_back(make_result(1'b0, '0, 1'b0, 1'b1));
    end else begin
      // flag the final dispatch of this tick
      r = scheduled_results.pop_back();
      r.last = 1'b1;
      scheduled_results.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < NUM_PERIODS; i++) period[i] = PERIOD_RESET[i];
      for (int i = 0; i < MAX_SLOTS; i++) begin
        last_run[i] = '0;
        ready[i]    = 1'b0;
      end
      tick_count = '0;
      running    = 1'b0;
      scheduled_results.delete();
      mismatches = 0;
      commands   = 0;
      dispatches = 0;
    end else begin
      if (result_valid) begin
        if (scheduled_results.size() == 0) begin
          $display("%0t: unexpected result due=%0d task=%0d tick=%0d state=%0d last=%0d",
                   $time, result.due, result.due_task, result.tick_now,
                   result.task_state, result.last);
          mismatches++;
        end else begin
          want = scheduled_results.pop_front();
          if (result !== want) begin
            $display("%0t: mismatch expected due=%0d task=%0d tick=%0d state=%0d last=%0d",
                     $time, want.due, want.due_task, want.tick_now,
                     want.task_state, want.last);
            $display("%0t:          actual   due=%0d task=%0d tick=%0d state=%0d last=%0d",
                     $time, result.due, result.due_task, result.tick_now,
                     result.task_state, result.last);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready && cfg_index < NUM_PERIODS) period[cfg_index] = cfg_data;
      if (start && !busy) begin
        commands++;
        advance_schedule(cmd);
      end
    end
    outstanding = scheduled_results.size();
  end

endmodule

// ===== sim/tb_periodic_task_dispatcher.sv =====
`timescale 1ns / 1ps

module tb_periodic_task_dispatcher;
  import ptd_pkg::*;

  localparam int TICK_MS      = 1;
  localparam int MAX_SLOTS    = 8;
  localparam int ACTIVE_TASKS = 7;
  localparam int LIMIT        = 100000;
  localparam int SETTLE       = 2 * ACTIVE_TASKS + 6;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 26;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  item_t                cmd = '0;
  result_t              result;
  logic                 result_valid;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PERIOD_W-1:0]  cfg_data = '0;

  logic cmd_taken = 1'b0;
  logic cfg_taken = 1'b0;
  int   cycles = 0;
  int   mismatches, outstanding, commands, dispatches;
  int   period_writes = 0;
  int   burst_left = 0;
  logic gaps_on = 1'b0;

  periodic_task_dispatcher #(
    .TICK_MS(TICK_MS), .MAX_SLOTS(MAX_SLOTS), .ACTIVE_TASKS(ACTIVE_TASKS)
  ) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .result(result), .result_valid(result_valid),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ptd_checker #(
    .TICK_MS(TICK_MS), .MAX_SLOTS(MAX_SLOTS), .ACTIVE_TASKS(ACTIVE_TASKS)
  ) chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .result(result), .result_valid(result_valid),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding),
    .commands(commands), .dispatches(dispatches)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cmd_taken <= start && !busy && !rst;
    cfg_taken <= cfg_valid && cfg_ready && !rst;
    cycles    <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb_periodic_task_dispatcher failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic issue(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id);
    if (gaps_on && burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
    cmd   <= '{mode: m, task_id: id};
    start <= 1'b1;
    do @(negedge clk); while (!cmd_taken);
    burst_left--;
  endtask

  // Write one period register once everything in flight has drained.
  task automatic write_period(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] val);
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0 || busy) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
    period_writes++;
  endtask

  function automatic logic [PERIOD_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return PERIOD_W'($urandom);
    return PERIOD_W'($urandom_range(1, 6));
  endfunction

  initial begin
    int r;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // stopped dispatcher, activate and query at the range edges, unused modes
    issue(M_TICK, 8'h00);
    issue(M_QUERY, 8'd0);
    issue(M_ACT, 8'd3);
    issue(M_QUERY, 8'd3);
    issue(M_ACT, 8'd200);
    issue(M_QUERY, 8'd200);
    issue(MODE_W'(5), 8'hFF);
    issue(MODE_W'(6), 8'h55);
    issue(MODE_W'(7), 8'hAA);
    // run on reset periods until slots 0 and 3 fall due
    issue(M_START, 8'h00);
    repeat (10) issue(M_TICK, 8'hFF);
    issue(M_SHUT, 8'h00);
    issue(M_TICK, 8'h00);
    issue(M_ACT, 8'd7);
    issue(M_QUERY, 8'd7);
    issue(M_START, 8'h00);
    issue(M_START, 8'h00);

    // period extremes; index 7 names no register
    write_period(3'd0, 16'd0);
    write_period(3'd1, 16'hFFFF);
    write_period(3'd2, 16'd1);
    write_period(3'd3, 16'd2);
    write_period(3'd4, 16'd0);
    write_period(3'd5, 16'hFFFF);
    write_period(3'd6, 16'd3);
    write_period(3'd7, 16'hFFFF);
    issue(M_START, 8'h00);
    repeat (6) issue(M_TICK, 8'h00);
    issue(M_QUERY, 8'd255);
    issue(M_ACT, 8'd255);

    for (int p = 0; p < PHASES; p++) begin
      for (int k = 0; k < NUM_PERIODS; k++) write_period(CFG_IDX_W'(k), pick_period());
      gaps_on = (p % 3 != 0);
      if ($urandom_range(0, 9) != 0) issue(M_START, ID_W'($urandom));
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        r = $urandom_range(0, 9);
        if (r < 7) issue(M_TICK, ID_W'($urandom));
        else if (r == 7) issue(MODE_W'($urandom_range(1, 7)), ID_W'($urandom_range(0, 255)));
        else issue(MODE_W'($urandom_range(1, 7)), ID_W'($urandom_range(0, 7)));
      end
    end

    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("Covered %0d commands and %0d task dispatches over %0d period writes.",
             commands, dispatches, period_writes);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_periodic_task_dispatcher passed");
    end else begin
      $display("tb_periodic_task_dispatcher failed");
    end
    $finish;
  end

endmodule

// ===== periodic_task_dispatcher.f =====
hw/rtl/ptd_pkg.sv
hw/rtl/ptd_seq.sv
hw/rtl/ptd_datapath.sv
hw/rtl/periodic_task_dispatcher.sv
sim/ptd_checker.sv
sim/tb_periodic_task_dispatcher.sv
